FILE: hdl/tpce_pkg.sv
// Shared constants and types of the trie prefix completion engine.
`timescale 1ns / 1ps
package tpce_pkg;
	localparam int TABLE_ENTRIES = 4096;
	localparam int MAX_DEPTH     = 32;
	localparam int SYMBOL_BITS   = 16;
	localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
	localparam int IDX_W         = $clog2(MAX_DEPTH);
	localparam int DEPTH_W       = $clog2(MAX_DEPTH + 1);
	localparam int ENTRY_W       = SYMBOL_BITS + 2 + ADDR_W;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_SYM   = 2'd1,
		KIND_END   = 2'd2,
		KIND_NEXT  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0]      child;
		logic                   last;
		logic                   final_mark;
		logic [SYMBOL_BITS-1:0] sym;
	} entry_t;
endpackage

FILE: hdl/tpce_table.sv
// Trie entry table: one write port, one registered read port.
`timescale 1ns / 1ps
module tpce_table import tpce_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  entry_t            wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output entry_t            rdata
);
	entry_t mem [TABLE_ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hdl/trie_prefix_completion_engine.sv
// Top level: command sequencer, path stack and result register.
//
// Input stream s_*: tuser carries the kind (write entry, prefix symbol, end prefix,
// next completion), tdata the entry fields and the prefix symbol.
// Output stream m_*: one transaction per completion letter, or one status item;
// tlast marks the final item of a response.
// Sequencing: a write goes straight to the table. A prefix symbol scans the
// sibling entries one at a time. End and next descend or backtrack one level at
// a time, then emit one letter at a time. All of it is set by the table
// memory's single read port with its registered read output.
// One command is in work at a time; s_tready is high only between commands.
// The result register lets the next command be taken while a result waits;
// a stalled receiver holds the sequencer at its next emitted item.
// Reset clears the prefix to the root list; the table holds nothing defined
// until entries are written, and needs no clearing pass.
`timescale 1ns / 1ps
module trie_prefix_completion_engine import tpce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] entry_address, [27:12] entry_symbol, [28] entry_final,
	// [29] entry_last, [41:30] entry_child, [57:42] prefix_symbol
	input  logic [63:0] s_tdata,
	// [1:0] kind
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [0] found, [16:1] symbol, [17] has_symbol, [23:18] matched_depth, [24] overflow
	output logic [31:0] m_tdata,
	output logic        m_tlast
);
	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_HEAD     = 14'b00000000000010,
		S_SCAN_RD  = 14'b00000000000100,
		S_SCAN_CHK = 14'b00000000001000,
		S_END      = 14'b00000000010000,
		S_DESC_RD  = 14'b00000000100000,
		S_DESC_CHK = 14'b00000001000000,
		S_NEXT_RD  = 14'b00000010000000,
		S_NEXT_CHK = 14'b00000100000000,
		S_BACK_RD  = 14'b00001000000000,
		S_BACK_CHK = 14'b00010000000000,
		S_EMIT_RD  = 14'b00100000000000,
		S_EMIT_OUT = 14'b01000000000000,
		S_RESP     = 14'b10000000000000
	} state_t;

	typedef enum logic [1:0] {
		M_ENTER = 2'b01,
		M_ITER  = 2'b10,
		M_DONE  = 2'b11
	} mode_t;

	state_t               state_q;
	mode_t                mode_q;
	logic [DEPTH_W-1:0]   pl_q, plen_q, n_q, i_q, ib_q;
	logic                 failed_q;
	logic [ADDR_W-1:0]    saved_q, st_q, cur_q;
	logic [ADDR_W-1:0]    k_q;
	logic [SYMBOL_BITS-1:0] psym_q;
	logic [ADDR_W-1:0]    stack_q [MAX_DEPTH];
	logic                 r_found_q, r_ovf_q;

	logic                 out_valid_q, out_found_q, out_has_q, out_last_q, out_ovf_q;
	logic [SYMBOL_BITS-1:0] out_sym_q;
	logic [DEPTH_W-1:0]   out_depth_q;

	logic                 accept, out_free, out_load;
	kind_t                kind;
	entry_t               wr_entry, rdata;
	logic                 re;
	logic [ADDR_W-1:0]    raddr;
	logic [IDX_W-1:0]     sridx;
	logic [ADDR_W-1:0]    srd;
	logic [DEPTH_W-1:0]   pl_m1, cnt, n_p1, emit_lvl;

	assign kind     = kind_t'(s_tuser);
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign out_load = out_free && (state_q == S_EMIT_OUT || state_q == S_RESP);
	assign pl_m1    = pl_q - DEPTH_W'(1);
	assign cnt      = plen_q - pl_q;
	assign n_p1     = n_q + DEPTH_W'(1);
	assign emit_lvl = pl_m1 + i_q;

	assign wr_entry.sym        = s_tdata[27:12];
	assign wr_entry.final_mark = s_tdata[28];
	assign wr_entry.last       = s_tdata[29];
	assign wr_entry.child      = s_tdata[30 +: ADDR_W];

	always_comb begin
		case (state_q)
			S_NEXT_RD: sridx = IDX_W'(plen_q - DEPTH_W'(1));
			S_BACK_RD: sridx = ib_q[IDX_W-1:0];
			S_EMIT_RD: sridx = emit_lvl[IDX_W-1:0];
			default:   sridx = pl_m1[IDX_W-1:0];
		endcase
	end
	assign srd = stack_q[sridx];

	always_comb begin
		re    = 1'b0;
		raddr = st_q;
		case (state_q)
			S_SCAN_RD, S_DESC_RD: begin
				re = 1'b1;
			end
			S_NEXT_RD: begin
				re    = (mode_q == M_ITER);
				raddr = srd;
			end
			S_BACK_RD, S_EMIT_RD: begin
				re    = 1'b1;
				raddr = srd;
			end
			default: re = 1'b0;
		endcase
	end

	tpce_table u_table (
		.clk   (clk),
		.we    (accept && kind == KIND_WRITE),
		.waddr (s_tdata[ADDR_W-1:0]),
		.wdata (wr_entry),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= M_ENTER;
			pl_q        <= DEPTH_W'(1);
			plen_q      <= DEPTH_W'(1);
			failed_q    <= 1'b0;
			saved_q     <= ADDR_W'(1);
			stack_q[0]  <= ADDR_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						psym_q <= s_tdata[42 +: SYMBOL_BITS];
						case (kind)
							KIND_SYM: begin
								if (mode_q != M_ENTER) begin
									stack_q[0] <= ADDR_W'(1);
									pl_q       <= DEPTH_W'(1);
									plen_q     <= DEPTH_W'(1);
									failed_q   <= 1'b0;
									mode_q     <= M_ENTER;
								end
								state_q <= S_HEAD;
							end
							KIND_END:  state_q <= S_END;
							KIND_NEXT: state_q <= S_NEXT_RD;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_HEAD: begin
					st_q <= srd;
					k_q  <= '0;
					if (failed_q) begin
						state_q <= S_IDLE;
					end else if (srd == '0) begin
						failed_q  <= 1'b1;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_SCAN_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CHK;
				S_SCAN_CHK: begin
					if (rdata.sym == psym_q) begin
						if (pl_q >= DEPTH_W'(MAX_DEPTH)) begin
							failed_q  <= 1'b1;
							r_found_q <= 1'b0;
							r_ovf_q   <= 1'b1;
							state_q   <= S_RESP;
						end else begin
							stack_q[pl_q[IDX_W-1:0]] <= rdata.child;
							pl_q    <= pl_q + DEPTH_W'(1);
							plen_q  <= pl_q + DEPTH_W'(1);
							state_q <= S_IDLE;
						end
					end else if (rdata.last || k_q == '1) begin
						failed_q  <= 1'b1;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						st_q    <= st_q + ADDR_W'(1);
						k_q     <= k_q + ADDR_W'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_END: begin
					logic [ADDR_W-1:0] head;
					head = (mode_q == M_ENTER) ? srd : saved_q;
					saved_q <= head;
					if (mode_q != M_ENTER) begin
						stack_q[pl_m1[IDX_W-1:0]] <= saved_q;
					end
					plen_q <= pl_q;
					st_q   <= head;
					n_q    <= pl_m1;
					if (failed_q || head == '0) begin
						mode_q    <= M_DONE;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						mode_q  <= M_ITER;
						state_q <= S_DESC_RD;
					end
				end
				S_DESC_RD: begin
					stack_q[n_q[IDX_W-1:0]] <= st_q;
					state_q <= S_DESC_CHK;
				end
				S_DESC_CHK: begin
					if (rdata.final_mark || rdata.child == '0) begin
						plen_q  <= n_p1;
						i_q     <= '0;
						state_q <= S_EMIT_RD;
					end else if (n_p1 >= DEPTH_W'(MAX_DEPTH)) begin
						plen_q    <= n_p1;
						mode_q    <= M_DONE;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b1;
						state_q   <= S_RESP;
					end else begin
						st_q    <= rdata.child;
						n_q     <= n_p1;
						state_q <= S_DESC_RD;
					end
				end
				S_NEXT_RD: begin
					if (mode_q != M_ITER) begin
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_NEXT_CHK;
					end
				end
				S_NEXT_CHK: begin
					if (rdata.child != '0) begin
						if (plen_q >= DEPTH_W'(MAX_DEPTH)) begin
							mode_q    <= M_DONE;
							r_found_q <= 1'b0;
							r_ovf_q   <= 1'b1;
							state_q   <= S_RESP;
						end else begin
							st_q    <= rdata.child;
							n_q     <= plen_q;
							state_q <= S_DESC_RD;
						end
					end else if (plen_q > pl_q) begin
						ib_q    <= plen_q - DEPTH_W'(2);
						state_q <= S_BACK_RD;
					end else begin
						mode_q    <= M_DONE;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end
				end
				S_BACK_RD: begin
					cur_q   <= srd;
					state_q <= S_BACK_CHK;
				end
				S_BACK_CHK: begin
					if (!rdata.last) begin
						st_q    <= cur_q + ADDR_W'(1);
						n_q     <= ib_q;
						state_q <= S_DESC_RD;
					end else if (ib_q > pl_m1) begin
						ib_q    <= ib_q - DEPTH_W'(1);
						state_q <= S_BACK_RD;
					end else begin
						mode_q    <= M_DONE;
						r_found_q <= 1'b0;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end
				end
				S_EMIT_RD: begin
					// empty completion: one letterless item
					if (cnt == '0) begin
						r_found_q <= 1'b1;
						r_ovf_q   <= 1'b0;
						state_q   <= S_RESP;
					end else begin
						state_q <= S_EMIT_OUT;
					end
				end
				S_EMIT_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= 1'b1;
						out_has_q   <= 1'b1;
						out_sym_q   <= rdata.sym;
						out_last_q  <= (i_q + DEPTH_W'(1) == cnt);
						out_depth_q <= pl_q;
						out_ovf_q   <= 1'b0;
						i_q         <= i_q + DEPTH_W'(1);
						state_q     <= (i_q + DEPTH_W'(1) == cnt) ? S_IDLE : S_EMIT_RD;
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= r_found_q;
						out_has_q   <= 1'b0;
						out_sym_q   <= '0;
						out_last_q  <= 1'b1;
						out_depth_q <= pl_q;
						out_ovf_q   <= r_ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'd0, out_ovf_q, 6'(out_depth_q), out_has_q, 16'(out_sym_q),
		out_found_q};

`ifndef SYNTH
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("sequencer state not one-hot");
	a_pl_range: assert property (@(posedge clk) disable iff (!arst_n)
		pl_q >= DEPTH_W'(1) && pl_q <= DEPTH_W'(MAX_DEPTH))
		else $error("prefix length out of range");
	a_plen_ge_pl: assert property (@(posedge clk) disable iff (!arst_n)
		plen_q >= pl_q) else $error("path shorter than prefix");
	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		accept && kind != KIND_WRITE |=> !s_tready)
		else $error("command not taken into work");
`endif
endmodule
